>>> rtl/sorted_priority_queue_unit_macros.svh
// Assertion macros used by the sorted priority queue unit.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/spq_pkg.sv
// Types and codes of the sorted priority queue.
package spq_pkg;

	localparam int CNT_W = 5;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] STAT_INSERTED = 2'd0;
	localparam logic [1:0] STAT_REMOVED  = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_data;
		logic signed [31:0] item_priority;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_data;
		logic signed [31:0] out_priority;
		logic [CNT_W-1:0]   entry_count;
	} result_t;

	typedef struct packed {
		logic signed [31:0] prio;
		logic signed [31:0] data;
	} entry_t;

endpackage

>>> rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: a circular entry store kept in ascending priority order.
// A remove reads the front entry from the idle state and reports it from the pop state.
// An insert into an empty store is written directly from the idle state; otherwise each
// stored entry with a higher priority number moves up one place per cycle before the new entry is written.
// Rejected requests report in the cycle after acceptance; busy is low whenever idle.
// Reset empties the queue at once; the result strobe cannot be stalled by the receiver.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spq_pkg::request_t request,
	output logic              done,
	output spq_pkg::result_t  result
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_POP   = 2'd3;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST : p - AW'(1);
	endfunction

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic          done_q;
	result_t       res_q;
	entry_t        new_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] left_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic          greater;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign tail_sum = {1'b0, head_q} + (AW+1)'(count_q);
	assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
		: tail_sum[AW-1:0];
	assign greater  = (mem_rdata.prio > new_q.prio);
	assign done     = done_q;
	assign result   = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = new_q;
		mem_raddr = ptr_dec(rp_q);
		unique case (state_q)
			ST_IDLE: begin
				mem_raddr = (request.kind == KIND_REMOVE) ? head_q : ptr_dec(tail);
				if (accept && request.kind == KIND_INSERT && is_empty) begin
					mem_we    = 1'b1;
					mem_waddr = tail;
					mem_wdata = '{prio: request.item_priority, data: request.item_data};
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (greater) begin
					mem_wdata = mem_rdata;
				end
			end
			ST_FINAL: begin
				mem_we = 1'b1;
			end
			ST_POP: begin
			end
			default: begin
			end
		endcase
	end

	spq_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			head_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (request.kind == KIND_INSERT) begin
							if (is_full) begin
								done_q <= 1'b1;
							end else if (is_empty) begin
								done_q  <= 1'b1;
								count_q <= count_q + CW'(1);
							end else begin
								state_q <= ST_SHIFT;
							end
						end else if (is_empty) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_SHIFT: begin
					if (!greater) begin
						done_q  <= 1'b1;
						count_q <= count_q + CW'(1);
						state_q <= ST_IDLE;
					end else if (left_q == '0) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					done_q  <= 1'b1;
					count_q <= count_q + CW'(1);
					state_q <= ST_IDLE;
				end
				ST_POP: begin
					done_q  <= 1'b1;
					count_q <= count_q - CW'(1);
					head_q  <= ptr_inc(head_q);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					new_q  <= '{prio: request.item_priority, data: request.item_data};
					rp_q   <= ptr_dec(tail);
					wp_q   <= tail;
					left_q <= AW'(count_q - CW'(1));
					if (request.kind == KIND_INSERT) begin
						res_q <= '{status: is_full ? STAT_FULL : STAT_INSERTED,
							out_data: '0, out_priority: '0,
							entry_count: CNT_W'(is_full ? count_q : count_q + CW'(1))};
					end else begin
						res_q <= '{status: STAT_EMPTY, out_data: '0, out_priority: '0,
							entry_count: CNT_W'(count_q)};
					end
				end
			end
			ST_SHIFT: begin
				if (greater) begin
					wp_q   <= rp_q;
					rp_q   <= ptr_dec(rp_q);
					left_q <= left_q - AW'(1);
				end
				res_q.entry_count <= CNT_W'(count_q + CW'(1));
			end
			ST_FINAL: begin
				res_q.entry_count <= CNT_W'(count_q + CW'(1));
			end
			ST_POP: begin
				res_q <= '{status: STAT_REMOVED, out_data: mem_rdata.data,
					out_priority: mem_rdata.prio, entry_count: CNT_W'(count_q - CW'(1))};
			end
			default: begin
			end
		endcase
	end

	`SPQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`SPQ_ASSERT_SAME(a_shift_not_full, clk, arst_n, state_q == ST_SHIFT, !is_full && !is_empty, "shift with full or empty store")
	`SPQ_ASSERT_NEXT(a_pop_entry, clk, arst_n, accept && request.kind == KIND_REMOVE && !is_empty, state_q == ST_POP, "remove did not start")
	`SPQ_ASSERT_NEXT(a_pop_result, clk, arst_n, state_q == ST_POP, done_q && res_q.status == STAT_REMOVED, "remove gave no result")

endmodule

>>> rtl/spq_mem.sv
// Entry store: one write port and one registered read port.
module spq_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  spq_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output spq_pkg::entry_t rdata
);
	import spq_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
